/* rtl/core/srfn_pkg.sv */
// Shared types, constants and kernel tables for the residual filter block.
package srfn_pkg;

   localparam int MAX_WIDTH_DEF  = 512;
   localparam int MAX_HEIGHT_DEF = 512;

   localparam int CFG_DIMW  = 10;
   localparam int CSR_IDXW  = 2;
   localparam int CSR_DATAW = 10;
   localparam int PIXW      = 8;
   localparam int GRAYW     = 16;
   localparam int MAGW      = 23;
   localparam int ACCW      = 25;
   localparam int COEFW     = 5;
   localparam int QW        = 8;
   localparam int NUMW      = MAGW + QW;
   localparam int TAPW      = 3;

   localparam logic                RST_KERNEL_SELECT = 1'b0;
   localparam logic [CFG_DIMW-1:0] RST_IMAGE_WIDTH   = 10'd512;
   localparam logic [CFG_DIMW-1:0] RST_IMAGE_HEIGHT  = 10'd512;
   localparam logic                RST_COLOR_MODE    = 1'b1;

   localparam logic [GRAYW-1:0] GRAY_R = 16'd77;
   localparam logic [GRAYW-1:0] GRAY_G = 16'd150;
   localparam logic [GRAYW-1:0] GRAY_B = 16'd29;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_FETCH = 1'b1;

   typedef enum logic [CSR_IDXW-1:0] {
      CSR_KERNEL_SELECT = 2'd0,
      CSR_IMAGE_WIDTH   = 2'd1,
      CSR_IMAGE_HEIGHT  = 2'd2,
      CSR_COLOR_MODE    = 2'd3
   } csr_index_type;

   localparam logic signed [COEFW-1:0] K3 [3][3] = '{
      '{-5'sd1,  5'sd2, -5'sd1},
      '{ 5'sd2, -5'sd4,  5'sd2},
      '{-5'sd1,  5'sd2, -5'sd1}
   };

   localparam logic signed [COEFW-1:0] K5 [5][5] = '{
      '{-5'sd1,  5'sd2, -5'sd2,  5'sd2, -5'sd1},
      '{ 5'sd2, -5'sd6,  5'sd8, -5'sd6,  5'sd2},
      '{-5'sd2,  5'sd8, -5'sd12, 5'sd8, -5'sd2},
      '{ 5'sd2, -5'sd6,  5'sd8, -5'sd6,  5'sd2},
      '{-5'sd1,  5'sd2, -5'sd2,  5'sd2, -5'sd1}
   };

   function automatic logic signed [COEFW-1:0] kernel_coef(input logic big,
                                                           input logic [TAPW-1:0] u,
                                                           input logic [TAPW-1:0] v);
      logic signed [COEFW-1:0] c;
      c = '0;
      if (big) begin
         if (u < 3'd5 && v < 3'd5) c = K5[u][v];
      end else begin
         if (u < 3'd3 && v < 3'd3) c = K3[u[1:0]][v[1:0]];
      end
      return c;
   endfunction

   typedef struct packed {
      logic load_write;
      logic frame_start;
      logic tap_issue;
      logic pixel_write;
      logic fetch_read;
      logic div_start;
      logic out_err;
      logic out_ok;
   } cmd_type;

   typedef struct packed {
      logic load_done;
      logic tap_last;
      logic pixel_last;
      logic div_done;
      logic fetch_last;
      logic out_busy;
   } status_type;

endpackage

/* rtl/core/srfn_req_if.sv */
// Request channel: command and pixel bytes.
interface srfn_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   modport source(output valid, command, red, green, blue, input ready);
   modport sink(input valid, command, red, green, blue, output ready);
endinterface

/* rtl/core/srfn_rsp_if.sv */
// Response channel: normalized pixel, last flag and status.
interface srfn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pixel_out;
   logic       last_pixel;
   logic       status;
   modport source(output valid, pixel_out, last_pixel, status, input ready);
   modport sink(input valid, pixel_out, last_pixel, status, output ready);
endinterface

/* rtl/core/srfn_csr_if.sv */
// Configuration write channel: register index and write data.
interface srfn_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [9:0] data;
   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

/* rtl/core/srm_residual_filter_normalize.sv */
// SRM residual filter with min/max normalization. After the last pixel the block
// runs a compute pass that reads the gray store once per kernel tap and then
// writes each pixel's magnitude, during which no transaction is taken. Each
// fetch runs the 8-step quotient divider before its response is registered,
// and no new transaction is taken meanwhile. Configuration writes are
// always taken and should be made between frames.
module srm_residual_filter_normalize
   import srfn_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   srfn_req_if.sink    req_ch,
   srfn_rsp_if.source  rsp_ch,
   srfn_csr_if.sink    csr_ch
);

   cmd_type    cmd;
   status_type st;

   assign csr_ch.ready = 1'b1;

   srfn_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_command (req_ch.command),
      .req_ready   (req_ch.ready),
      .st          (st),
      .cmd         (cmd)
   );

   srfn_datapath #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_ch.valid && csr_ch.ready),
      .csr_index      (csr_ch.index),
      .csr_data       (csr_ch.data),
      .req_red        (req_ch.red),
      .req_green      (req_ch.green),
      .req_blue       (req_ch.blue),
      .cmd            (cmd),
      .st             (st),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_pixel_out  (rsp_ch.pixel_out),
      .rsp_last_pixel (rsp_ch.last_pixel),
      .rsp_status     (rsp_ch.status)
   );

endmodule

/* rtl/core/srfn_ctrl.sv */
// Controller state machine sequencing load, convolution and fetch.
module srfn_ctrl
   import srfn_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_command,
   output logic       req_ready,
   input  status_type st,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_ISSUE,
      ST_DRAIN,
      ST_WRITE,
      ST_READY,
      ST_FSTART,
      ST_FDIV
   } state_type;

   state_type state_ff, state_in;
   logic      accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      case (state_ff)
         ST_LOAD: begin
            req_ready = !st.out_busy;
            if (accept) begin
               if (req_command == CMD_LOAD) begin
                  cmd.load_write = 1'b1;
                  if (st.load_done) begin
                     cmd.frame_start = 1'b1;
                     state_in        = ST_ISSUE;
                  end
               end else begin
                  cmd.out_err = 1'b1;
               end
            end
         end
         ST_ISSUE: begin
            cmd.tap_issue = 1'b1;
            if (st.tap_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_WRITE;
         ST_WRITE: begin
            cmd.pixel_write = 1'b1;
            state_in = st.pixel_last ? ST_READY : ST_ISSUE;
         end
         ST_READY: begin
            req_ready = !st.out_busy;
            // Loads in this phase are taken and dropped.
            if (accept && req_command == CMD_FETCH) begin
               cmd.fetch_read = 1'b1;
               state_in       = ST_FSTART;
            end
         end
         ST_FSTART: begin
            cmd.div_start = 1'b1;
            state_in      = ST_FDIV;
         end
         ST_FDIV: begin
            if (st.div_done) begin
               cmd.out_ok = 1'b1;
               state_in   = st.fetch_last ? ST_LOAD : ST_READY;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* rtl/core/srfn_div.sv */
// Restoring divider giving an 8-bit quotient, one bit per cycle.
module srfn_div
   import srfn_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [NUMW-1:0] num,
   input  logic [MAGW-1:0] den,
   output logic            done,
   output logic [QW-1:0]   quotient
);

   localparam int CW = $clog2(QW);

   logic [NUMW-1:0]   rem_ff;
   logic [NUMW-2:0]   div_ff;
   logic [QW-1:0]     q_ff;
   logic [CW-1:0]     cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic              fits;

   assign fits     = NUMW'(div_ff) <= rem_ff;
   assign done     = done_ff;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CW'(QW - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         div_ff <= {den, {(QW-1){1'b0}}};
         q_ff   <= '0;
      end else if (busy_ff) begin
         if (fits) rem_ff <= rem_ff - NUMW'(div_ff);
         q_ff   <= {q_ff[QW-2:0], fits};
         div_ff <= div_ff >> 1;
      end
   end

endmodule

/* rtl/core/srfn_datapath.sv */
// Datapath: configuration, frame stores, convolution MAC, min/max and output register.
module srfn_datapath
   import srfn_pkg::*;
#(
   parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write,
   input  logic [CSR_IDXW-1:0]  csr_index,
   input  logic [CSR_DATAW-1:0] csr_data,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   input  cmd_type              cmd,
   output status_type           st,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [PIXW-1:0]      rsp_pixel_out,
   output logic                 rsp_last_pixel,
   output logic                 rsp_status
);

   localparam int DW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int CNTW  = $clog2(DEPTH + 1);
   localparam int SW    = ((DW > HW) ? DW : HW) + 2;
   localparam int OW    = AW + 2;

   // Configuration registers.
   logic                ks_ff;
   logic [CFG_DIMW-1:0] width_ff;
   logic [CFG_DIMW-1:0] height_ff;
   logic                cm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ks_ff     <= RST_KERNEL_SELECT;
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         cm_ff     <= RST_COLOR_MODE;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_KERNEL_SELECT: ks_ff     <= csr_data[0];
            CSR_IMAGE_WIDTH:   width_ff  <= csr_data[CFG_DIMW-1:0];
            CSR_IMAGE_HEIGHT:  height_ff <= csr_data[CFG_DIMW-1:0];
            CSR_COLOR_MODE:    cm_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   logic [DW-1:0]   w_cl;
   logic [HW-1:0]   h_cl;
   logic [CNTW-1:0] total_cfg;

   assign w_cl = (width_ff == '0) ? DW'(1) :
                 ((int'(width_ff) > MAX_WIDTH) ? DW'(MAX_WIDTH) : DW'(width_ff));
   assign h_cl = (height_ff == '0) ? HW'(1) :
                 ((int'(height_ff) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_ff));
   assign total_cfg = CNTW'(w_cl) * CNTW'(h_cl);

   // Load side.
   logic [CNTW-1:0]  load_cnt_ff;
   logic             load_room;
   logic [GRAYW-1:0] gray_val;

   assign load_room = load_cnt_ff < total_cfg;
   assign st.load_done = ({1'b0, load_cnt_ff} + 1'b1) >= {1'b0, total_cfg};
   assign gray_val = cm_ff ? (GRAYW'(req_red) * GRAY_R + GRAYW'(req_green) * GRAY_G
                              + GRAYW'(req_blue) * GRAY_B)
                           : {req_red, 8'h00};

   // Frame geometry latched when the frame completes.
   logic [DW-1:0]   fw_ff;
   logic [HW-1:0]   fh_ff;
   logic            big_ff;
   logic [CNTW-1:0] total_f_ff;

   logic [HW-1:0]   pr_ff;
   logic [DW-1:0]   pc_ff;
   logic [AW-1:0]   pix_ff;
   logic [TAPW-1:0] tu_ff;
   logic [TAPW-1:0] tv_ff;
   logic [OW-1:0]   roff_ff;
   logic [CNTW-1:0] fetch_cnt_ff;

   logic [TAPW-1:0] half;
   logic [TAPW-1:0] tap_max;
   logic [OW-1:0]   roff_cfg;
   logic [OW-1:0]   roff_lat;
   logic [SW-1:0]   s_pos;
   logic [SW-1:0]   t_pos;
   logic            tap_ok;
   logic [OW-1:0]   addr_full;

   assign half     = big_ff ? TAPW'(2) : TAPW'(1);
   assign tap_max  = big_ff ? TAPW'(4) : TAPW'(2);
   assign roff_cfg = ks_ff ? (OW'(0) - (OW'(w_cl) << 1)) : (OW'(0) - OW'(w_cl));
   assign roff_lat = big_ff ? (OW'(0) - (OW'(fw_ff) << 1)) : (OW'(0) - OW'(fw_ff));

   // Offsets wrap modulo the wide width; only in-frame taps are used.
   assign s_pos     = SW'(pr_ff) + SW'(tu_ff) - SW'(half);
   assign t_pos     = SW'(pc_ff) + SW'(tv_ff) - SW'(half);
   assign tap_ok    = (s_pos < SW'(fh_ff)) && (t_pos < SW'(fw_ff));
   assign addr_full = OW'(pix_ff) + roff_ff + OW'(tv_ff) - OW'(half);

   assign st.tap_last   = (tu_ff == tap_max) && (tv_ff == tap_max);
   assign st.pixel_last = ({1'b0, pix_ff} + 1'b1) == (AW+1)'(total_f_ff);
   assign st.fetch_last = ({1'b0, fetch_cnt_ff} + 1'b1) == {1'b0, total_f_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff  <= '0;
         fetch_cnt_ff <= '0;
         fw_ff        <= '0;
         fh_ff        <= '0;
         big_ff       <= 1'b0;
         total_f_ff   <= '0;
         pr_ff        <= '0;
         pc_ff        <= '0;
         pix_ff       <= '0;
         tu_ff        <= '0;
         tv_ff        <= '0;
         roff_ff      <= '0;
      end else begin
         if (cmd.load_write && load_room) load_cnt_ff <= load_cnt_ff + 1'b1;
         if (cmd.frame_start) begin
            load_cnt_ff  <= '0;
            fetch_cnt_ff <= '0;
            fw_ff        <= w_cl;
            fh_ff        <= h_cl;
            big_ff       <= ks_ff;
            total_f_ff   <= total_cfg;
            pr_ff        <= '0;
            pc_ff        <= '0;
            pix_ff       <= '0;
            tu_ff        <= '0;
            tv_ff        <= '0;
            roff_ff      <= roff_cfg;
         end
         if (cmd.tap_issue && !st.tap_last) begin
            if (tv_ff == tap_max) begin
               tv_ff   <= '0;
               tu_ff   <= tu_ff + 1'b1;
               roff_ff <= roff_ff + OW'(fw_ff);
            end else begin
               tv_ff <= tv_ff + 1'b1;
            end
         end
         if (cmd.pixel_write) begin
            tu_ff   <= '0;
            tv_ff   <= '0;
            roff_ff <= roff_lat;
            pix_ff  <= pix_ff + 1'b1;
            if ({1'b0, pc_ff} + 1'b1 == (DW+1)'(fw_ff)) begin
               pc_ff <= '0;
               pr_ff <= pr_ff + 1'b1;
            end else begin
               pc_ff <= pc_ff + 1'b1;
            end
         end
         if (cmd.out_ok) begin
            fetch_cnt_ff <= st.fetch_last ? '0 : fetch_cnt_ff + 1'b1;
         end
      end
   end

   // Gray frame store.
   logic [GRAYW-1:0] gray_mem [DEPTH];
   logic [GRAYW-1:0] gray_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_write && load_room) gray_mem[load_cnt_ff[AW-1:0]] <= gray_val;
      if (cmd.tap_issue) gray_rd_ff <= gray_mem[addr_full[AW-1:0]];
   end

   // Multiply-accumulate one tap per cycle, in the cycle after the read.
   logic                    mac_ff;
   logic                    tap_ok_d_ff;
   logic signed [COEFW-1:0] coef_d_ff;
   logic signed [ACCW-1:0]  acc_ff;
   logic signed [GRAYW+COEFW:0] prod;

   assign prod = $signed({1'b0, gray_rd_ff}) * coef_d_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= 1'b0;
      end else begin
         mac_ff <= cmd.tap_issue;
      end
   end

   always_ff @(posedge clock) begin
      tap_ok_d_ff <= tap_ok;
      coef_d_ff   <= kernel_coef(big_ff, tu_ff, tv_ff);
      if (cmd.frame_start || cmd.pixel_write) begin
         acc_ff <= '0;
      end else if (mac_ff && tap_ok_d_ff) begin
         acc_ff <= acc_ff + ACCW'(prod);
      end
   end

   // Magnitude store and frame extremes.
   logic [MAGW-1:0] mag;
   logic [MAGW-1:0] mag_mem [DEPTH];
   logic [MAGW-1:0] mag_rd_ff;
   logic [MAGW-1:0] min_ff;
   logic [MAGW-1:0] max_ff;

   assign mag = acc_ff[ACCW-1] ? MAGW'(-acc_ff) : MAGW'(acc_ff);

   always_ff @(posedge clock) begin
      if (cmd.pixel_write) mag_mem[pix_ff] <= mag;
      if (cmd.fetch_read) mag_rd_ff <= mag_mem[fetch_cnt_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_ff <= '0;
         max_ff <= '0;
      end else if (cmd.pixel_write) begin
         if (pix_ff == '0 || mag < min_ff) min_ff <= mag;
         if (pix_ff == '0 || mag > max_ff) max_ff <= mag;
      end
   end

   // Normalization: (mag - min) * 255 / range.
   logic [MAGW-1:0] diff;
   logic [MAGW-1:0] range_v;
   logic [MAGW-1:0] den;
   logic [NUMW-1:0] num;
   logic [QW-1:0]   quotient;

   assign diff    = (mag_rd_ff >= min_ff) ? (mag_rd_ff - min_ff) : '0;
   assign range_v = max_ff - min_ff;
   assign den     = (range_v == '0) ? MAGW'(1) : range_v;
   assign num     = {diff, {QW{1'b0}}} - NUMW'(diff);

   srfn_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .num      (num),
      .den      (den),
      .done     (st.div_done),
      .quotient (quotient)
   );

   // Output register.
   logic            out_valid_ff;
   logic [PIXW-1:0] out_pixel_ff;
   logic            out_last_ff;
   logic            out_status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_err || cmd.out_ok) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_err) begin
         out_pixel_ff  <= '0;
         out_last_ff   <= 1'b0;
         out_status_ff <= 1'b1;
      end else if (cmd.out_ok) begin
         out_pixel_ff  <= PIXW'(quotient);
         out_last_ff   <= st.fetch_last;
         out_status_ff <= 1'b0;
      end
   end

   assign st.out_busy    = out_valid_ff && !rsp_ready;
   assign rsp_valid      = out_valid_ff;
   assign rsp_pixel_out  = out_pixel_ff;
   assign rsp_last_pixel = out_last_ff;
   assign rsp_status     = out_status_ff;

endmodule

/* tb/srfn_checker.sv */
// Checker for the residual filter: predicts every response and compares it.
module srfn_checker
   import srfn_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   srfn_req_if   req_mon,
   srfn_rsp_if   rsp_mon,
   srfn_csr_if   csr_mon,
   output int    fail_count,
   output int    pending
);

   localparam int FRAME_MAX_W = 512;
   localparam int FRAME_MAX_H = 512;
   localparam int DEPTH       = FRAME_MAX_W * FRAME_MAX_H;

   typedef struct packed {
      logic [PIXW-1:0] pixel_out;
      logic            last_pixel;
      logic            status;
   } fetch_result_type;

   fetch_result_type expected_q[$];

   bit [GRAYW-1:0] gray_mem [DEPTH];
   bit [MAGW-1:0]  mag_mem  [DEPTH];

   logic                kernel_big;
   logic [CFG_DIMW-1:0] width_reg;
   logic [CFG_DIMW-1:0] height_reg;
   logic                rgb_mode;
   int unsigned         loaded;
   int unsigned         fetched;
   int unsigned         mag_min;
   int unsigned         mag_max;
   int unsigned         frame_w;
   int unsigned         frame_h;
   bit                  ready_phase;

   function automatic int unsigned limit_dim(int unsigned v, int unsigned maxv);
      if (v == 0) return 1;
      if (v > maxv) return maxv;
      return v;
   endfunction

   function automatic int unsigned residual_at(int r, int c, logic big);
      int  half;
      int  size;
      int  s;
      int  t;
      int  coef;
      longint acc;
      half = big ? 2 : 1;
      size = big ? 5 : 3;
      acc = 0;
      for (int u = 0; u < size; u++) begin
         for (int v = 0; v < size; v++) begin
            s = r + u - half;
            t = c + v - half;
            if (s >= 0 && s < int'(frame_h) && t >= 0 && t < int'(frame_w)) begin
               coef = big ? int'(K5[u][v]) : int'(K3[u][v]);
               acc += longint'(gray_mem[s * frame_w + t]) * coef;
            end
         end
      end
      if (acc < 0) acc = -acc;
      return 32'(acc) & 32'h7F_FFFF;
   endfunction

   task automatic filter_frame();
      int unsigned idx;
      int unsigned m;
      frame_w = limit_dim(width_reg, FRAME_MAX_W);
      frame_h = limit_dim(height_reg, FRAME_MAX_H);
      for (int r = 0; r < int'(frame_h); r++) begin
         for (int c = 0; c < int'(frame_w); c++) begin
            idx = r * frame_w + c;
            m = residual_at(r, c, kernel_big);
            mag_mem[idx] = m;
            if (idx == 0 || m < mag_min) mag_min = m;
            if (idx == 0 || m > mag_max) mag_max = m;
         end
      end
      fetched = 0;
      ready_phase = 1;
   endtask

   task automatic report_mismatch(string field, int got, int want);
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   task automatic predict_request(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned total;
      longint unsigned span;
      longint unsigned scaled;
      fetch_result_type res;
      if (cmd == CMD_LOAD) begin
         if (!ready_phase) begin
            total = limit_dim(width_reg, FRAME_MAX_W) * limit_dim(height_reg, FRAME_MAX_H);
            if (loaded < total) begin
               gray_mem[loaded] = rgb_mode ? GRAY_R * r + GRAY_G * g + GRAY_B * b
                                           : {r, 8'h00};
               loaded++;
            end
            if (loaded >= total) begin
               filter_frame();
               loaded = 0;
            end
         end
      end else if (!ready_phase) begin
         res = '{pixel_out: '0, last_pixel: 1'b0, status: 1'b1};
         expected_q.push_back(res);
      end else begin
         span = mag_max - mag_min;
         if (span == 0) span = 1;
         scaled = (mag_mem[fetched] >= mag_min) ? mag_mem[fetched] - mag_min : 0;
         scaled = scaled * 255 / span;
         if (scaled > 255) scaled = 255;
         fetched++;
         res.pixel_out = scaled[7:0];
         res.status = 1'b0;
         res.last_pixel = (fetched >= frame_w * frame_h);
         if (res.last_pixel) begin
            fetched = 0;
            loaded = 0;
            ready_phase = 0;
         end
         expected_q.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         kernel_big  = RST_KERNEL_SELECT;
         width_reg   = RST_IMAGE_WIDTH;
         height_reg  = RST_IMAGE_HEIGHT;
         rgb_mode    = RST_COLOR_MODE;
         loaded      = 0;
         fetched     = 0;
         mag_min     = 0;
         mag_max     = 0;
         frame_w     = 0;
         frame_h     = 0;
         ready_phase = 0;
         expected_q.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected response, pixel_out", rsp_mon.pixel_out, -1);
            end else begin
               if (rsp_mon.pixel_out !== expected_q[0].pixel_out)
                  report_mismatch("pixel_out", rsp_mon.pixel_out, expected_q[0].pixel_out);
               if (rsp_mon.last_pixel !== expected_q[0].last_pixel)
                  report_mismatch("last_pixel", rsp_mon.last_pixel, expected_q[0].last_pixel);
               if (rsp_mon.status !== expected_q[0].status)
                  report_mismatch("status", rsp_mon.status, expected_q[0].status);
               void'(expected_q.pop_front());
            end
         end
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_index_type'(csr_mon.index))
               CSR_KERNEL_SELECT: kernel_big = csr_mon.data[0];
               CSR_IMAGE_WIDTH:   width_reg  = csr_mon.data;
               CSR_IMAGE_HEIGHT:  height_reg = csr_mon.data;
               CSR_COLOR_MODE:    rgb_mode   = csr_mon.data[0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready)
            predict_request(req_mon.command, req_mon.red, req_mon.green, req_mon.blue);
      end
      pending = expected_q.size();
   end

   initial begin
      fail_count = 0;
      pending = 0;
   end

endmodule

/* tb/testbench.sv */
// Top of the residual filter testbench: stimulus, response stalls and verdict.
module testbench;
   import srfn_pkg::*;

   localparam int IDLE_LIMIT  = 200000;
   localparam int SETTLE      = 40;
   localparam int ITEM_TARGET = 1700;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   int   items_sent;
   int   idle_cycles;
   int   big_frames;
   bit   quiet;

   srfn_req_if req();
   srfn_rsp_if rsp();
   srfn_csr_if csr();

   srm_residual_filter_normalize dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req),
      .rsp_ch (rsp),
      .csr_ch (csr)
   );

   srfn_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req),
      .rsp_mon    (rsp),
      .csr_mon    (csr),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Response side: after each transaction the sink holds ready low for a drawn stall.
   initial begin
      int stall;
      stall = 0;
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp.ready <= 1'b0;
            stall = 0;
         end else if (rsp.valid && rsp.ready) begin
            stall = quiet ? 0 : $urandom_range(0, 12);
            if (stall != 0) rsp.ready <= 1'b0;
         end else if (!rsp.ready) begin
            if (stall <= 1) rsp.ready <= 1'b1;
            if (stall > 0) stall--;
         end
      end
   end

   initial begin
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   function automatic int unsigned frame_pixels(int unsigned w, int unsigned h);
      int unsigned cw;
      int unsigned ch;
      cw = (w == 0) ? 1 : (w > 512 ? 512 : w);
      ch = (h == 0) ? 1 : (h > 512 ? 512 : h);
      return cw * ch;
   endfunction

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // A valid left high after a transaction is either replaced by the next item in
   // the same step or lowered here, so one signal never gets two assignments.
   task automatic send(logic cmd, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 12);
      csr.valid <= 1'b0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.command <= cmd;
      req.red     <= r;
      req.green   <= g;
      req.blue    <= b;
      req.valid   <= 1'b1;
      do @(posedge clock); while (!req.ready);
      items_sent++;
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      csr.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // The write valid stays high into the next call and is lowered by the next send.
   task automatic csr_write(csr_index_type idx, logic [9:0] value);
      csr.index <= idx;
      csr.data  <= value;
      csr.valid <= 1'b1;
      do @(posedge clock); while (!csr.ready);
   endtask

   task automatic load_pixels(int unsigned n, bit noise);
      for (int unsigned i = 0; i < n; i++) begin
         if (noise && $urandom_range(0, 9) == 0) send(CMD_FETCH, pick_byte(), 8'h00, 8'h00);
         send(CMD_LOAD, pick_byte(), pick_byte(), pick_byte());
      end
   endtask

   task automatic fetch_pixels(int unsigned n, bit noise);
      for (int unsigned i = 0; i < n; i++) begin
         if (noise && $urandom_range(0, 9) == 0) send(CMD_LOAD, pick_byte(), pick_byte(), 8'h00);
         send(CMD_FETCH, pick_byte(), pick_byte(), pick_byte());
      end
   endtask

   task automatic run_frame(logic ks, logic [9:0] w, logic [9:0] h, logic cm, bit noise);
      int unsigned total;
      drain();
      csr_write(CSR_KERNEL_SELECT, {9'd0, ks});
      csr_write(CSR_IMAGE_WIDTH, w);
      csr_write(CSR_IMAGE_HEIGHT, h);
      csr_write(CSR_COLOR_MODE, {9'd0, cm});
      total = frame_pixels(w, h);
      load_pixels(total, noise);
      fetch_pixels(total, noise);
   endtask

   initial begin
      logic [9:0] w;
      logic [9:0] h;
      items_sent = 0;
      big_frames = 0;
      quiet = 1'b0;
      reset <= 1'b1;
      req.valid   <= 1'b0;
      req.command <= CMD_LOAD;
      req.red     <= '0;
      req.green   <= '0;
      req.blue    <= '0;
      csr.valid   <= 1'b0;
      csr.index   <= CSR_KERNEL_SELECT;
      csr.data    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Fetch before any frame is loaded reports an error status.
      send(CMD_FETCH, 8'hFF, 8'hFF, 8'hFF);

      // Zero dimensions count as one pixel; a load in the fetch phase is dropped.
      drain();
      csr_write(CSR_IMAGE_WIDTH, 10'd0);
      csr_write(CSR_IMAGE_HEIGHT, 10'd0);
      csr_write(CSR_COLOR_MODE, 10'd0);
      send(CMD_LOAD, 8'hFF, 8'h00, 8'h00);
      send(CMD_LOAD, 8'h12, 8'h34, 8'h56);
      send(CMD_FETCH, 8'h00, 8'h00, 8'h00);

      // Saturated 2x2 RGB frame through the 5x5 kernel.
      drain();
      csr_write(CSR_KERNEL_SELECT, 10'd1);
      csr_write(CSR_IMAGE_WIDTH, 10'd2);
      csr_write(CSR_IMAGE_HEIGHT, 10'd2);
      csr_write(CSR_COLOR_MODE, 10'd1);
      repeat (4) send(CMD_LOAD, 8'hFF, 8'hFF, 8'hFF);
      repeat (4) send(CMD_FETCH, 8'h00, 8'h00, 8'h00);

      // Frame shrunk while loading: the next load is dropped and the frame completes.
      drain();
      csr_write(CSR_KERNEL_SELECT, 10'd0);
      send(CMD_LOAD, 8'h00, 8'h00, 8'h00);
      send(CMD_LOAD, 8'hFF, 8'h80, 8'h01);
      send(CMD_LOAD, 8'h7F, 8'hFF, 8'h00);
      drain();
      csr_write(CSR_IMAGE_HEIGHT, 10'd1);
      csr_write(CSR_COLOR_MODE, 10'd0);
      send(CMD_LOAD, 8'hAA, 8'h55, 8'hAA);
      repeat (2) send(CMD_FETCH, 8'h00, 8'h00, 8'h00);

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 4) == 0) quiet = ~quiet;
         if (big_frames < 3 && $urandom_range(0, 29) == 0) begin
            big_frames++;
            case ($urandom_range(0, 3))
               0: begin w = 10'd1023; h = 10'd1;    end
               1: begin w = 10'd512;  h = 10'd0;    end
               2: begin w = 10'd1;    h = 10'd512;  end
               default: begin w = 10'd0; h = 10'd1023; end
            endcase
         end else if ($urandom_range(0, 9) == 0) begin
            w = 10'($urandom_range(0, 1)) | 10'h200 & {10{$urandom_range(0, 1) == 1}};
            h = 10'($urandom_range(0, 1));
         end else begin
            w = 10'($urandom_range(1, 6));
            h = 10'($urandom_range(1, 6));
         end
         run_frame(1'($urandom), w, h, 1'($urandom), $urandom_range(0, 3) != 0);
      end

      drain();
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/srfn_pkg.sv
rtl/core/srfn_req_if.sv
rtl/core/srfn_rsp_if.sv
rtl/core/srfn_csr_if.sv
rtl/core/srfn_ctrl.sv
rtl/core/srfn_div.sv
rtl/core/srfn_datapath.sv
rtl/core/srm_residual_filter_normalize.sv
tb/srfn_checker.sv
tb/testbench.sv
